// ===== sv/its_pkg.sv =====
// Package for the icosphere triangle subdivider: payload structs, constants,
// register indexes and state encodings. No dependencies.
`default_nettype none
package its_pkg;
    localparam int unsigned MaxVertices = 65536;
    localparam int unsigned CntW = 17;

    localparam logic [0:0] REG_RADIUS = 1'b0;
    localparam logic [0:0] REG_FIRST  = 1'b1;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;

    typedef struct packed {
        logic signed [31:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [15:0] corner_a_index, corner_b_index, corner_c_index;
    } t_in;

    typedef struct packed {
        logic kind;
        logic last;
        logic signed [31:0] pos_x, pos_y, pos_z;
        logic signed [15:0] normal_x, normal_y, normal_z;
        logic [15:0] tri_first, tri_second, tri_third;
        logic overflow;
    } t_out;

    // Classified job passed from front to back.
    typedef struct packed {
        logic [2:0][2:0][32:0] mid;   // per edge, per axis, midpoint sign+magnitude
        logic [2:0][15:0] cidx;
        logic [2:0][15:0] nidx;
        logic ovf;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_NORM, S_SQ, S_SQRT, S_DIV, S_VOUT, S_TOUT
    } t_state;
endpackage
`default_nettype wire

// ===== sv/icosphere_triangle_subdivider_top.sv =====
// Top level: configuration registers, front end, back end.
// Depends on its_pkg, its_front, its_back.
//
// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_ready          i_data (t_in)
// result    out        o_valid / i_ready          o_data (t_out)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Per triangle the back end handles each edge with a 32-step square root and six
// long divisions on one shared divider; an edge with a zero midpoint skips both.
// A stalled result holds the back end at its output step. The front end holds
// two classified triangles, so input transfers continue while results stall,
// until both slots are full.
// Reset is synchronous and active low.
`default_nettype none
module icosphere_triangle_subdivider_top import its_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_data
);
    logic [30:0] r_radius;
    logic job_valid, job_ready;
    t_job job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_radius <= 31'd65536;
        else if (i_cfg_valid && i_cfg_index == REG_RADIUS) r_radius <= i_cfg_data;
    end

    its_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    its_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .i_radius(r_radius), .o_valid, .i_ready, .o_data
    );
endmodule
`default_nettype wire

// ===== sv/its_front.sv =====
// Front end: accepts triangles, forms edge midpoints, assigns vertex indices.
// Depends on its_pkg.
`default_nettype none
module its_front import its_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in         i_data,
    input  wire logic        i_cfg_valid,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_data,
    output logic             o_job_valid,
    input  wire logic        i_job_ready,
    output t_job             o_job
);
    logic [CntW-1:0] r_cnt, n_cnt;
    t_job r_q [2];
    logic [1:0] r_fill;
    logic r_wp, r_rp;
    logic push, pop;
    t_job job;
    logic signed [32:0] sum;
    logic signed [31:0] pa [3][3];

    assign o_ready     = (r_fill != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_fill != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_comb begin
        pa[0][0] = i_data.ax; pa[0][1] = i_data.ay; pa[0][2] = i_data.az;
        pa[1][0] = i_data.bx; pa[1][1] = i_data.by; pa[1][2] = i_data.bz;
        pa[2][0] = i_data.cx; pa[2][1] = i_data.cy; pa[2][2] = i_data.cz;
        job = '0;
        sum = '0;
        // Midpoint is the 33-bit sum shifted right, i.e. floor halving.
        for (int e = 0; e < 3; e++) begin
            for (int a = 0; a < 3; a++) begin
                sum = 33'(signed'(pa[e][a])) + 33'(signed'(pa[(e+1)%3][a]));
                job.mid[e][a] = {sum[32], sum[32] ? 32'(-(sum >>> 1)) : 32'(sum >>> 1)};
            end
        end
        job.cidx[0] = i_data.corner_a_index;
        job.cidx[1] = i_data.corner_b_index;
        job.cidx[2] = i_data.corner_c_index;
        n_cnt = r_cnt;
        for (int k = 0; k < 3; k++) begin
            if (n_cnt < CntW'(MaxVertices)) begin
                job.nidx[k] = n_cnt[15:0];
                n_cnt = n_cnt + 1'b1;
            end else begin
                job.nidx[k] = 16'(MaxVertices - 1);
                job.ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= CntW'(12);
            r_fill <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == REG_FIRST) begin
                r_cnt <= {1'b0, i_cfg_data[15:0]};
            end else if (push) begin
                r_cnt <= n_cnt;
            end
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= job;
    end
endmodule
`default_nettype wire

// ===== sv/its_back.sv =====
// Back end: normalizes each edge midpoint with a shared bit-serial square root
// and divider, emitting one vertex per edge, then four child triangles. Uses its_pkg.
`default_nettype none
module its_back import its_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_job_valid,
    output logic             o_job_ready,
    input  wire t_job        i_job,
    input  wire logic [30:0] i_radius,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data
);
    t_state r_state, n_state;
    t_job r_job;
    logic [1:0] r_edge;
    logic [1:0] r_ax;
    logic [2:0] r_k;
    logic [29:0] r_mag [3];
    logic [2:0] r_neg;
    logic [63:0] r_s, r_rem;
    logic [31:0] r_len;
    logic [63:0] r_root;
    logic [5:0] r_it;
    logic [62:0] r_num;
    logic [62:0] r_drem;
    logic [62:0] r_quo;
    logic r_pass;
    logic r_zero;
    logic [15:0] r_nrm [3][3];
    logic [31:0] r_pos [3][3];
    logic r_ov;
    t_out r_out;

    logic [32:0] m0, m1, m2, mx;
    logic [63:0] trial;
    logic [63:0] drem_sh;
    logic [31:0] cur;
    logic [63:0] rem_cur;
    logic [29:0] sh_mag [3];
    logic        ld_out;
    t_out        n_out;

    assign o_valid = r_ov;
    assign o_data  = r_out;
    assign o_job_ready = (r_state == S_IDLE);

    always_comb begin
        m0 = {1'b0, r_job.mid[r_edge][0][31:0]};
        m1 = {1'b0, r_job.mid[r_edge][1][31:0]};
        m2 = {1'b0, r_job.mid[r_edge][2][31:0]};
        mx = (m0 > m1) ? m0 : m1;
        mx = (mx > m2) ? mx : m2;
        trial = r_root | (64'd1 << {r_it, 1'b0});
        drem_sh = {r_drem, r_num[62]};
        cur = {2'b00, r_mag[r_ax]};
        rem_cur = (r_it == 6'd31) ? r_s : r_rem;
        // Bring the largest magnitude into [2^29, 2^30) by a joint shift.
        for (int a = 0; a < 3; a++) begin
            sh_mag[a] = '0;
        end
        for (int sh = 0; sh < 30; sh++) begin
            if (mx >= (33'd1 << 29) >> sh && mx < (33'd1 << 30) >> sh) begin
                sh_mag[0] = 30'(m0 << sh);
                sh_mag[1] = 30'(m1 << sh);
                sh_mag[2] = 30'(m2 << sh);
            end
        end
        for (int sh = 1; sh < 3; sh++) begin
            if (mx >= (33'd1 << (29 + sh)) && mx < (33'd1 << (30 + sh))) begin
                sh_mag[0] = 30'(m0 >> sh);
                sh_mag[1] = 30'(m1 >> sh);
                sh_mag[2] = 30'(m2 >> sh);
            end
        end
    end

    always_comb begin
        ld_out = (r_state == S_VOUT || r_state == S_TOUT) && (!r_ov || i_ready);
        n_out = '0;
        n_out.overflow = r_job.ovf;
        if (r_state == S_TOUT) begin
            n_out.kind = KIND_TRI;
            n_out.last = (r_k == 3'd3);
            case (r_k)
                3'd0: begin
                    n_out.tri_first  = r_job.cidx[0];
                    n_out.tri_second = r_job.nidx[0];
                    n_out.tri_third  = r_job.nidx[2];
                end
                3'd1: begin
                    n_out.tri_first  = r_job.nidx[0];
                    n_out.tri_second = r_job.cidx[1];
                    n_out.tri_third  = r_job.nidx[1];
                end
                3'd2: begin
                    n_out.tri_first  = r_job.nidx[1];
                    n_out.tri_second = r_job.cidx[2];
                    n_out.tri_third  = r_job.nidx[2];
                end
                default: begin
                    n_out.tri_first  = r_job.nidx[0];
                    n_out.tri_second = r_job.nidx[1];
                    n_out.tri_third  = r_job.nidx[2];
                end
            endcase
        end else begin
            n_out.kind      = KIND_VERTEX;
            n_out.pos_x     = r_pos[r_edge][0];
            n_out.pos_y     = r_pos[r_edge][1];
            n_out.pos_z     = r_pos[r_edge][2];
            n_out.normal_x  = r_nrm[r_edge][0];
            n_out.normal_y  = r_nrm[r_edge][1];
            n_out.normal_z  = r_nrm[r_edge][2];
            n_out.tri_first = r_job.nidx[r_edge];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_job_valid) n_state = S_LOAD;
            S_LOAD: n_state = S_NORM;
            S_NORM: n_state = r_zero ? S_VOUT : S_SQ;
            S_SQ:   n_state = S_SQRT;
            S_SQRT: if (r_it == 6'd0) n_state = S_DIV;
            S_DIV:  if (r_it == 6'd0 && r_ax == 2'd2 && r_pass) n_state = S_VOUT;
            S_VOUT: if (!r_ov || i_ready) n_state = (r_edge == 2'd2) ? S_TOUT : S_LOAD;
            S_TOUT: if ((!r_ov || i_ready) && r_k == 3'd3) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ld_out) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job  <= i_job;
                r_edge <= 2'd0;
                r_k    <= 3'd0;
            end
            S_LOAD: begin
                r_zero <= (mx == 33'd0);
                for (int a = 0; a < 3; a++) begin
                    r_neg[a] <= r_job.mid[r_edge][a][32];
                    r_mag[a] <= sh_mag[a];
                end
                r_ax <= 2'd0;
                r_s  <= '0;
            end
            S_NORM: begin
                for (int a = 0; a < 3; a++) begin
                    r_nrm[r_edge][a] <= '0;
                    r_pos[r_edge][a] <= '0;
                end
            end
            S_SQ: begin
                r_s <= 64'({30'd0, r_mag[0]} * r_mag[0]) + 64'({30'd0, r_mag[1]} * r_mag[1])
                     + 64'({30'd0, r_mag[2]} * r_mag[2]);
                r_root <= '0;
                r_it   <= 6'd31;
            end
            S_SQRT: begin
                // One result bit per cycle, restoring form.
                if (rem_cur >= trial) begin
                    r_rem  <= rem_cur - trial;
                    r_root <= (r_root >> 1) | (64'd1 << {r_it, 1'b0});
                end else begin
                    r_rem  <= rem_cur;
                    r_root <= r_root >> 1;
                end
                if (r_it == 6'd0) begin
                    r_len <= 32'((trial <= rem_cur) ?
                             ((r_root >> 1) | 64'd1) : (r_root >> 1));
                    r_ax   <= 2'd0;
                    r_pass <= 1'b0;
                    r_it   <= 6'd63;
                end else begin
                    r_it <= r_it - 1'b1;
                end
            end
            S_DIV: begin
                if (r_it == 6'd63) begin
                    // Numerator: mag * scale + len/2, then long division by len.
                    r_num  <= 63'({31'd0, cur} * (r_pass ? {32'd0, i_radius} : 63'd16384))
                            + 63'(r_len >> 1);
                    r_drem <= '0;
                    r_quo  <= '0;
                    r_it   <= 6'd62;
                end else begin
                    r_num <= r_num << 1;
                    if (drem_sh >= {32'd0, r_len}) begin
                        r_drem <= 63'(drem_sh - {32'd0, r_len});
                        r_quo  <= {r_quo[61:0], 1'b1};
                    end else begin
                        r_drem <= 63'(drem_sh);
                        r_quo  <= {r_quo[61:0], 1'b0};
                    end
                    if (r_it == 6'd0) begin
                        if (r_pass) r_pos[r_edge][r_ax] <= r_neg[r_ax] ?
                            32'(-{r_quo[61:0], drem_sh >= {32'd0, r_len}}) :
                            32'({r_quo[61:0], drem_sh >= {32'd0, r_len}});
                        else r_nrm[r_edge][r_ax] <= r_neg[r_ax] ?
                            16'(-{r_quo[61:0], drem_sh >= {32'd0, r_len}}) :
                            16'({r_quo[61:0], drem_sh >= {32'd0, r_len}});
                        if (r_ax == 2'd2) begin
                            r_ax <= 2'd0;
                            r_pass <= 1'b1;
                        end else begin
                            r_ax <= r_ax + 1'b1;
                        end
                        r_it <= 6'd63;
                    end else begin
                        r_it <= r_it - 1'b1;
                    end
                end
            end
            S_VOUT: begin
                if (ld_out) r_edge <= r_edge + 1'b1;
            end
            S_TOUT: begin
                if (ld_out) r_k <= r_k + 1'b1;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/its_checker.sv =====
// Port-level checker for the subdivider, bound to the top level.
// Depends on its_pkg.
`default_nettype none
module its_checker import its_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("stall");
    a_last_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last |-> o_data.kind == KIND_TRI) else $error("last kind");
    a_vtx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_VERTEX |-> o_data.tri_second == 16'd0)
        else $error("vertex fields");
    a_tri_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_TRI |-> o_data.pos_x == 32'd0)
        else $error("tri fields");
endmodule

bind icosphere_triangle_subdivider_top its_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_data
);
`default_nettype wire
